// ===== src/lru_age_victim_table_core_assert.svh =====
// Assertion macros shared by the LRU age table RTL.
// Needs a clock and an active-low reset in scope at the point of use.
`ifndef LRU_AGE_VICTIM_TABLE_CORE_ASSERT_SVH
`define LRU_AGE_VICTIM_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define LAVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lavt assertion failed");

// next-cycle implication
`define LAVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lavt assertion failed");

`endif

// ===== src/lavt_pkg.sv =====
// Shared types and constants for the LRU age victim table.
// No dependencies; used by the interfaces, controller, datapath and top level.
package lavt_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int AGE_W       = 16;
  localparam logic [AGE_W-1:0] MAX_AGE = 16'hFFFF;

  // active entry count register
  localparam int ACT_W = 5;
  localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;
  localparam int LIVE_W = (ACT_W > IDX_W + 1) ? ACT_W : IDX_W + 1;

  // configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] REG_ACTIVE = 1'b0;

  typedef enum logic [1:0] {
    OP_TOUCH = 2'd0,
    OP_PICK  = 2'd1,
    OP_SET   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  typedef struct packed {
    logic capture;  // latch the incoming item
    logic scan;     // register the minimum search
    logic apply;    // write back state, load result
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free; // result register empty or being taken
  } dp_stat_t;

endpackage

// ===== src/lavt_if.sv =====
// Valid/ready channel interfaces for items in and results out.
// Depends on lavt_pkg for field widths.
interface lavt_in_if import lavt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic [IDX_W-1:0] entry_index;
  logic             set_open;
  logic             set_permanent;
  logic             set_locked;
  logic             set_member;

  modport source (output valid, op, entry_index, set_open, set_permanent,
                  set_locked, set_member, input ready);
  modport sink   (input valid, op, entry_index, set_open, set_permanent,
                  set_locked, set_member, output ready);
endinterface

interface lavt_out_if import lavt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AGE_W-1:0] age_given;
  logic             renormalized;
  logic             victim_found;
  logic [IDX_W-1:0] victim_index;

  modport source (output valid, age_given, renormalized, victim_found, victim_index,
                  input ready);
  modport sink   (input valid, age_given, renormalized, victim_found, victim_index,
                  output ready);
endinterface

// ===== src/lavt_ctrl.sv =====
// Controller FSM: capture, scan, apply sequence for each item.
// Depends on lavt_pkg.
module lavt_ctrl import lavt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        // next item may enter while this one writes back
        if (stat.out_free) begin
          cmd.apply = 1'b1;
          in_ready  = 1'b1;
          if (in_valid) begin
            cmd.capture = 1'b1;
            state_nxt   = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/lavt_datapath.sv =====
// Datapath: entry table, age counter, minimum-age tree, result register.
// Depends on lavt_pkg.
module lavt_datapath import lavt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_cmd_t        cmd,
  output dp_stat_t         stat,
  input  logic [ACT_W-1:0] active,
  // item fields
  input  logic [1:0]       in_op,
  input  logic [IDX_W-1:0] in_entry_index,
  input  logic             in_set_open,
  input  logic             in_set_permanent,
  input  logic             in_set_locked,
  input  logic             in_set_member,
  // result
  output logic             out_valid,
  input  logic             out_ready,
  output logic [AGE_W-1:0] out_age_given,
  output logic             out_renormalized,
  output logic             out_victim_found,
  output logic [IDX_W-1:0] out_victim_index
);

  // captured item
  logic [1:0]       op_r;
  logic [IDX_W-1:0] idx_r;
  logic             sopen_r, sperm_r, slock_r, smemb_r;

  // table state
  logic [AGE_W-1:0]       age_r   [NUM_ENTRIES];
  logic [AGE_W-1:0]       age_nxt [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] open_r, open_nxt;
  logic [NUM_ENTRIES-1:0] perm_r, perm_nxt;
  logic [NUM_ENTRIES-1:0] lock_r, lock_nxt;
  logic [NUM_ENTRIES-1:0] memb_r, memb_nxt;
  logic [AGE_W-1:0]       cnt_r, cnt_nxt;

  // scan result
  logic             min_found_r;
  logic [AGE_W-1:0] min_age_r;
  logic [IDX_W-1:0] min_idx_r;

  // result register
  logic             out_valid_r;
  logic [AGE_W-1:0] age_given_r, age_given_nxt;
  logic             renorm_r, renorm_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] vidx_r, vidx_nxt;

  logic [NUM_ENTRIES-1:0] live, elig;
  logic                   idx_live;
  logic [AGE_W-1:0]       oldest, drop, cnt_shift, cnt_wrap, cnt_inc;

  // heap-ordered min tree, node 1 is the root, leaves at NUM_ENTRIES + i
  logic             nd_vld [1:2*NUM_ENTRIES-1];
  logic [AGE_W-1:0] nd_age [1:2*NUM_ENTRIES-1];
  logic [IDX_W-1:0] nd_idx [1:2*NUM_ENTRIES-1];

  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      live[i] = LIVE_W'(i) < LIVE_W'(active);
      // touch wants the oldest non-member age; pick wants an evictable entry
      elig[i] = live[i] && (age_r[i] != '0) && !memb_r[i] &&
                ((op_r == OP_TOUCH) || (open_r[i] && !perm_r[i] && !lock_r[i]));
    end
  end

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_leaf
    assign nd_vld[NUM_ENTRIES+g] = elig[g];
    assign nd_age[NUM_ENTRIES+g] = age_r[g];
    assign nd_idx[NUM_ENTRIES+g] = IDX_W'(g);
  end

  // left child covers lower indices; ties go right
  for (genvar k = 1; k < NUM_ENTRIES; k++) begin : g_node
    logic take_hi;
    assign take_hi   = nd_vld[2*k+1] &&
                       (!nd_vld[2*k] || (nd_age[2*k+1] <= nd_age[2*k]));
    assign nd_vld[k] = nd_vld[2*k] || nd_vld[2*k+1];
    assign nd_age[k] = take_hi ? nd_age[2*k+1] : nd_age[2*k];
    assign nd_idx[k] = take_hi ? nd_idx[2*k+1] : nd_idx[2*k];
  end

  // wrap arithmetic
  assign idx_live  = LIVE_W'(idx_r) < LIVE_W'(active);
  assign oldest    = min_found_r ? min_age_r : MAX_AGE;
  assign drop      = oldest - AGE_W'(1);
  assign cnt_shift = MAX_AGE - drop;
  assign cnt_wrap  = (cnt_shift == MAX_AGE) ? MAX_AGE : cnt_shift + AGE_W'(1);
  assign cnt_inc   = cnt_r + AGE_W'(1);

  always_comb begin
    age_nxt       = age_r;
    open_nxt      = open_r;
    perm_nxt      = perm_r;
    lock_nxt      = lock_r;
    memb_nxt      = memb_r;
    cnt_nxt       = cnt_r;
    age_given_nxt = '0;
    renorm_nxt    = 1'b0;
    found_nxt     = 1'b0;
    vidx_nxt      = '0;
    case (op_r)
      OP_TOUCH: begin
        if (idx_live) begin
          if (perm_r[idx_r]) begin
            age_nxt[idx_r] = '0;
          end else if (cnt_r == MAX_AGE) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
              if (live[i] && (age_r[i] != '0)) begin
                age_nxt[i] = (age_r[i] > drop) ? age_r[i] - drop : AGE_W'(1);
              end
            end
            age_nxt[idx_r] = cnt_wrap;
            cnt_nxt        = cnt_wrap;
            age_given_nxt  = cnt_wrap;
            renorm_nxt     = 1'b1;
          end else begin
            age_nxt[idx_r] = cnt_inc;
            cnt_nxt        = cnt_inc;
            age_given_nxt  = cnt_inc;
          end
        end
      end
      OP_PICK: begin
        if (min_found_r) begin
          age_nxt[min_idx_r]  = '0;
          open_nxt[min_idx_r] = 1'b0;
          found_nxt           = 1'b1;
          vidx_nxt            = min_idx_r;
        end
      end
      OP_SET: begin
        if (idx_live) begin
          open_nxt[idx_r] = sopen_r;
          perm_nxt[idx_r] = sperm_r;
          lock_nxt[idx_r] = slock_r;
          memb_nxt[idx_r] = smemb_r;
          age_nxt[idx_r]  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // item and scan registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      idx_r   <= in_entry_index;
      sopen_r <= in_set_open;
      sperm_r <= in_set_permanent;
      slock_r <= in_set_locked;
      smemb_r <= in_set_member;
    end
    if (cmd.scan) begin
      min_found_r <= nd_vld[1];
      min_age_r   <= nd_age[1];
      min_idx_r   <= nd_idx[1];
    end
    if (cmd.apply) begin
      age_given_r <= age_given_nxt;
      renorm_r    <= renorm_nxt;
      found_r     <= found_nxt;
      vidx_r      <= vidx_nxt;
    end
  end

  // table state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        age_r[i] <= '0;
      end
      open_r <= '0;
      perm_r <= '0;
      lock_r <= '0;
      memb_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.apply) begin
      age_r  <= age_nxt;
      open_r <= open_nxt;
      perm_r <= perm_nxt;
      lock_r <= lock_nxt;
      memb_r <= memb_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_free    = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_age_given    = age_given_r;
  assign out_renormalized = renorm_r;
  assign out_victim_found = found_r;
  assign out_victim_index = vidx_r;

endmodule

// ===== src/lru_age_victim_table_core.sv =====
// LRU age victim table, top level. An accepted item goes through the min-age
// scan, then write-back into the result register, which raises result valid.
// A new item is captured while the previous one writes back. The 16-entry min
// tree is scanned into a register before the table write-back; a result that is
// not taken stalls the input. Reset: synchronous active-low rst_n clears all ages,
// attributes and the age counter, sets active_entries to 16 and leaves the block idle and ready for items.
// Depends on lavt_pkg, lavt_if, lavt_ctrl, lavt_datapath and the assert macros.
`include "lru_age_victim_table_core_assert.svh"

module lru_age_victim_table_core import lavt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lavt_in_if.sink               in_item,
  lavt_out_if.source            out_item,
  // APB-style configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // active_entries register; index is the word address
  logic [ACT_W-1:0]      active_r;
  logic [CFG_ADDR_W-3:0] reg_idx;
  logic                  cfg_wr;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACT_RESET;
    end else if (cfg_wr && (reg_idx == REG_ACTIVE)) begin
      active_r <= pwdata[ACT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_ACTIVE) begin
      prdata = {{(CFG_DATA_W-ACT_W){1'b0}}, active_r};
    end
  end

  // sequencer: idle -> scan -> apply, with the next item captured during apply
  lavt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table, min tree and result register
  lavt_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .active           (active_r),
    .in_op            (in_item.op),
    .in_entry_index   (in_item.entry_index),
    .in_set_open      (in_item.set_open),
    .in_set_permanent (in_item.set_permanent),
    .in_set_locked    (in_item.set_locked),
    .in_set_member    (in_item.set_member),
    .out_valid        (out_item.valid),
    .out_ready        (out_item.ready),
    .out_age_given    (out_item.age_given),
    .out_renormalized (out_item.renormalized),
    .out_victim_found (out_item.victim_found),
    .out_victim_index (out_item.victim_index)
  );

  // a captured item is always scanned on the following cycle
  `LAVT_ASSERT_NEXT(a_capture_then_scan, clk, rst_n, cmd.capture, cmd.scan)
  // a write-back always presents a result next cycle
  `LAVT_ASSERT_NEXT(a_apply_then_valid, clk, rst_n, cmd.apply, out_item.valid)
  // a renormalizing touch never hands out age zero
  `LAVT_ASSERT_NOW(a_renorm_age, clk, rst_n, out_item.valid && out_item.renormalized,
    out_item.age_given != '0)
  // pick results and touch results are exclusive
  `LAVT_ASSERT_NOW(a_pick_excl, clk, rst_n, out_item.valid && out_item.victim_found,
    !out_item.renormalized && (out_item.age_given == '0))

endmodule
